FILE: sv/nsf_pkg.sv
// Shared types, codes and helpers for the NMEA sentence framer.
// No dependencies; imported by every module of the block.
package nsf_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PR_LO = 8'h20;
  localparam logic [7:0] CH_PR_HI = 8'h7E;

  localparam int unsigned CFG_W = 9;
  localparam int unsigned LEN_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_BODY  = 3'd1,
    ST_HEXHI = 3'd2,
    ST_HEXLO = 3'd3,
    ST_CR    = 3'd4,
    ST_LF    = 3'd5,
    ST_END   = 3'd6,
    ST_EOF   = 3'd7
  } nsf_state_t;

  // One received character as it leaves the input register.
  typedef struct packed {
    logic [7:0] chr;
    logic       eoi;
  } nsf_item_t;

  // One result item.
  typedef struct packed {
    logic             overflow;
    logic             checksum_ok;
    logic [7:0]       checksum_recv;
    logic [7:0]       checksum_calc;
    logic [LEN_W-1:0] sentence_length;
    logic             sentence_done;
    logic [7:0]       save_index;
    logic [7:0]       save_byte;
    logic             save_valid;
    logic [2:0]       state_code;
  } nsf_result_t;

  // Uppercase hex digit decode: {valid, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

FILE: sv/nsf_in_reg.sv
// Input register stage of the NMEA sentence framer: holds one request
// until the framer takes it. Depends on nsf_pkg.
module nsf_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tuser,   // [0] end_of_input
  input  logic              take,
  output logic              item_valid,
  output nsf_pkg::nsf_item_t item
);
  import nsf_pkg::*;

  logic      valid_r;
  nsf_item_t item_r;

  // Refill in the same cycle the held request is taken.
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= '{chr: in_tdata, eoi: in_tuser};
    end
  end

endmodule

FILE: sv/nsf_framer.sv
// Sentence framing state machine: state, byte count, running XOR and
// received checksum, with the single-step update. Depends on nsf_pkg.
module nsf_framer #(
  parameter int unsigned MAX_BUFFER = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  nsf_pkg::nsf_item_t          item,
  input  logic [nsf_pkg::CFG_W-1:0]   buffer_size,
  output nsf_pkg::nsf_result_t        result
);
  import nsf_pkg::*;

  localparam int unsigned BW_W = $clog2(MAX_BUFFER + 1);
  localparam int unsigned CW   = (BW_W > CFG_W) ? BW_W : CFG_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BUFFER);

  nsf_state_t     state_r, state_nxt, st0;
  logic [BW_W-1:0] bw_r, bw_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic [7:0]     recv_r, recv_nxt;

  logic [7:0]     c;
  logic           is_start;
  logic [CW-1:0]  size, base, base1;
  logic           fits, fits2;
  logic [4:0]     hx;
  logic           save, done, ovf;

  assign c        = item.chr;
  assign is_start = (c == CH_DOLL) || (c == CH_BANG);
  assign size     = (CW'(buffer_size) > MAX_C) ? MAX_C : CW'(buffer_size);
  assign hx       = hex_decode(c);

  // Restart characters force the hunt before the per-state decision.
  always_comb begin
    st0 = state_r;
    if (item.eoi) begin
      st0 = ST_EOF;
    end else if (c == CH_NUL || is_start) begin
      st0 = ST_HUNT;
    end else if (c == CH_CR || c == CH_LF) begin
      st0 = state_r;
    end else if (c < CH_PR_LO || c > CH_PR_HI) begin
      st0 = ST_HUNT;
    end
  end

  // A new sentence counts from zero.
  assign base  = (st0 == ST_HUNT && is_start) ? '0 : CW'(bw_r);
  assign base1 = base + CW'(1);
  assign fits  = base < size;
  assign fits2 = base1 < size;

  // Next state
  always_comb begin
    state_nxt = st0;
    case (st0)
      ST_HUNT: begin
        if (is_start && size != '0) begin
          state_nxt = ST_BODY;
        end
      end
      ST_BODY: begin
        if (!fits) begin
          state_nxt = ST_HUNT;
        end else if (c == CH_STAR) begin
          state_nxt = ST_HEXHI;
        end
      end
      ST_HEXHI: state_nxt = (hx[4] && fits) ? ST_HEXLO : ST_HUNT;
      ST_HEXLO: state_nxt = (hx[4] && fits) ? ST_CR : ST_HUNT;
      ST_CR:    state_nxt = (c == CH_CR && fits) ? ST_LF : ST_HUNT;
      ST_LF:    state_nxt = (c == CH_LF && fits2) ? ST_END : ST_HUNT;
      default:  state_nxt = st0;
    endcase
  end

  // Step outputs
  always_comb begin
    save = 1'b0;
    done = 1'b0;
    ovf  = 1'b0;
    case (st0)
      ST_HUNT: begin
        if (is_start) begin
          save = size != '0;
          ovf  = size == '0;
        end
      end
      ST_BODY: begin
        save = fits;
        ovf  = !fits;
      end
      ST_HEXHI, ST_HEXLO: begin
        save = hx[4] && fits;
        ovf  = hx[4] && !fits;
      end
      ST_CR: begin
        save = (c == CH_CR) && fits;
        ovf  = (c == CH_CR) && !fits;
      end
      ST_LF: begin
        save = (c == CH_LF) && fits2;
        done = (c == CH_LF) && fits2;
        ovf  = (c == CH_LF) && !fits2;
      end
      default: begin
        save = 1'b0;
      end
    endcase
  end

  always_comb begin
    xor_nxt  = xor_r;
    recv_nxt = recv_r;
    if (st0 == ST_HUNT && is_start) begin
      xor_nxt = 8'h00;
    end
    if (save && st0 == ST_BODY && c != CH_STAR) begin
      xor_nxt = xor_r ^ c;
    end
    if (save && st0 == ST_HEXHI) begin
      recv_nxt = {hx[3:0], 4'h0};
    end
    if (save && st0 == ST_HEXLO) begin
      recv_nxt = {recv_r[7:4], hx[3:0]};
    end
  end

  // Count the LF and the implied NUL on completion.
  always_comb begin
    if (st0 == ST_EOF) begin
      bw_nxt = '0;
    end else if (done) begin
      bw_nxt = BW_W'(base + CW'(2));
    end else if (save) begin
      bw_nxt = BW_W'(base1);
    end else begin
      bw_nxt = BW_W'(base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      bw_r    <= '0;
      xor_r   <= 8'h00;
      recv_r  <= 8'h00;
    end else if (step_en) begin
      state_r <= state_nxt;
      bw_r    <= bw_nxt;
      xor_r   <= xor_nxt;
      recv_r  <= recv_nxt;
    end
  end

  always_comb begin
    result.state_code      = state_nxt;
    result.save_valid      = save;
    result.save_byte       = save ? c : 8'h00;
    result.save_index      = save ? base[7:0] : 8'h00;
    result.sentence_done   = done;
    result.sentence_length = done ? LEN_W'(base + CW'(2)) : '0;
    result.checksum_calc   = xor_nxt;
    result.checksum_recv   = recv_nxt;
    result.checksum_ok     = done && (xor_nxt == recv_nxt);
    result.overflow        = ovf;
  end

endmodule

FILE: sv/nmea_sentence_framer_unit.sv
// NMEA 0183 sentence framer, top level: configuration register, input
// register, framer and result register. Depends on nsf_pkg, nsf_in_reg, nsf_framer.
//
// Usage: one received character enters per request on the in_ channel
// (in_tdata = character, in_tuser = end-of-input flag). Every request
// yields exactly one result request on the out_ channel carrying the state
// after the character, the stored byte and its buffer index, and at the
// closing LF the sentence length and the checksum comparison.
// The character sits in the input register and passes through the framer
// into the result register, which drives out_tvalid.
// Throughput is one character per cycle while out_tready stays high; the
// single state update per character through the framer sets that figure.
// When the receiver holds out_tready low, the result register holds and the
// input register takes one more request only if it is empty; in_tready then drops.
// Reset (rst_n low, synchronous) empties both registers, puts the framer
// in the hunt state with count, XOR and received checksum at zero, and
// sets buffer_size to 256. Write cfg_wr_data with cfg_wr_en only while idle.
module nmea_sentence_framer_unit #(
  parameter int unsigned MAX_BUFFER = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [nsf_pkg::CFG_W-1:0] cfg_wr_data,  // buffer_size
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,     // [7:0] in_byte
  input  logic                      in_tuser,     // [0] end_of_input
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [2:0] state_code, [3] save_valid, [11:4] save_byte, [19:12] save_index,
  // [20] sentence_done, [29:21] sentence_length, [37:30] checksum_calc,
  // [45:38] checksum_recv, [46] checksum_ok, [47] overflow
  output logic [47:0]               out_tdata
);
  import nsf_pkg::*;

  logic [CFG_W-1:0] buf_size_r;
  logic             item_valid;
  nsf_item_t        item;
  logic             advance;
  nsf_result_t      res;
  nsf_result_t      res_r;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      buf_size_r <= cfg_wr_data;
    end
  end

  // Step the framer when the result register is free or being drained.
  assign advance = item_valid && (!out_valid_r || out_tready);

  nsf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  nsf_framer #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (item),
    .buffer_size (buf_size_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.overflow, res_r.checksum_ok, res_r.checksum_recv,
                       res_r.checksum_calc, res_r.sentence_length,
                       res_r.sentence_done, res_r.save_index, res_r.save_byte,
                       res_r.save_valid, res_r.state_code};

endmodule
